/* rtl/sha256_stream_hasher_defines.svh */
// assertion macros shared by the sha256 stream hasher checker
`ifndef SHA256_STREAM_HASHER_DEFINES_SVH
`define SHA256_STREAM_HASHER_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define SHS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("shs check failed");

// consequent must hold in the cycle after the antecedent
`define SHS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("shs check failed");

`endif

/* rtl/shs_pkg.sv */
// shared types for the sha256 stream hasher
`timescale 1ns / 1ps

package shs_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROUND,
        S_FOLD,
        S_PAD,
        S_EMIT
    } t_state;

    // padding progress after the final transaction
    typedef enum logic [1:0] {
        P_MARK,
        P_ZERO,
        P_LEN
    } t_phase;

    // working variables of the compression
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
        logic [31:0] f;
        logic [31:0] g;
        logic [31:0] h;
    } t_vars;

    // message schedule window taps, w0 is the word of the current round
    typedef struct packed {
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w9;
        logic [31:0] w14;
    } t_taps;

endpackage

/* rtl/shs_round.sv */
// one sha256 round and one message schedule step, shared over all 64 rounds
`timescale 1ns / 1ps

module shs_round
    import shs_pkg::*;
(
    input  t_vars       i_vars,
    input  t_taps       i_taps,
    input  logic [5:0]  i_round,
    output t_vars       o_vars,
    output logic [31:0] o_w_new
);

    localparam logic [31:0] K_TAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] f_big0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] f_big1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] f_sig0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] f_sig1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

    logic [31:0] w_choose;
    logic [31:0] w_major;
    logic [31:0] w_t1;
    logic [31:0] w_t2;

    assign w_choose = (i_vars.e & i_vars.f) ^ (~i_vars.e & i_vars.g);
    assign w_major  = (i_vars.a & i_vars.b) ^ (i_vars.a & i_vars.c) ^ (i_vars.b & i_vars.c);
    assign w_t1     = i_vars.h + f_big1(i_vars.e) + w_choose + K_TAB[i_round] + i_taps.w0;
    assign w_t2     = f_big0(i_vars.a) + w_major;

    assign o_vars.a = w_t1 + w_t2;
    assign o_vars.b = i_vars.a;
    assign o_vars.c = i_vars.b;
    assign o_vars.d = i_vars.c;
    assign o_vars.e = i_vars.d + w_t1;
    assign o_vars.f = i_vars.e;
    assign o_vars.g = i_vars.f;
    assign o_vars.h = i_vars.g;

    // word sixteen rounds ahead
    assign o_w_new = f_sig1(i_taps.w14) + i_taps.w9 + f_sig0(i_taps.w1) + i_taps.w0;

endmodule

/* rtl/sha256_stream_hasher.sv */
// sha256 stream hasher top level: byte intake, padding, round sequencer, digest output
//
// channel  dir  handshake                    payload
// in       in   i_in_valid / o_in_ready      i_data_byte, i_has_byte, i_last
// out      out  o_out_valid / i_out_ready    o_digest_word, o_word_index, o_digest_end
//
// completing a 64-byte block runs all 64 rounds on the shared round unit, then a fold
// a last transaction pads one byte per cycle (up to 72 bytes, one or two blocks),
// pausing while a completed block is hashed, with a step that adds no byte before
// the length bytes, then offers eight digest words
// o_in_ready is low from a block completion until its fold is done,
// and from a last transaction until the eighth digest word is taken
// i_rst_n (synchronous, active low) restores the initial hash and clears counts
`timescale 1ns / 1ps

module sha256_stream_hasher
    import shs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_last,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_digest_end
);

    localparam logic [31:0] IV_TAB [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };
    localparam logic [5:0] FILL_LAST  = 6'd63;
    localparam logic [5:0] LEN_START  = 6'd56;
    localparam logic [5:0] ROUND_LAST = 6'd63;
    localparam logic [2:0] IDX_LAST   = 3'd7;
    localparam logic [7:0] PAD_MARK   = 8'h80;

    t_state      r_state, n_state;
    t_phase      r_phase, n_phase;
    logic        r_pad, n_pad;
    logic [5:0]  r_fill, n_fill;
    logic [5:0]  r_round, n_round;
    logic [2:0]  r_idx, n_idx;
    logic [63:0] r_bits, n_bits;
    logic [31:0] r_hash [8];
    logic [31:0] n_hash [8];
    t_vars       r_work, n_work;
    // block buffer and message schedule window share one shift line
    logic [31:0] r_win [16];
    logic [31:0] n_win [16];

    logic        ins_en;
    logic [7:0]  ins_byte;
    logic [2:0]  len_sel;
    t_taps       rnd_taps;
    t_vars       rnd_vars;
    logic [31:0] rnd_w_new;

    assign rnd_taps = '{w0: r_win[0], w1: r_win[1], w9: r_win[9], w14: r_win[14]};

    shs_round u_shs_round (
        .i_vars  (r_work),
        .i_taps  (rnd_taps),
        .i_round (r_round),
        .o_vars  (rnd_vars),
        .o_w_new (rnd_w_new)
    );

    // length byte 0 is the top byte of the bit count
    assign len_sel = ~r_fill[2:0];

    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_pad    = r_pad;
        n_fill   = r_fill;
        n_round  = r_round;
        n_idx    = r_idx;
        n_bits   = r_bits;
        n_hash   = r_hash;
        n_work   = r_work;
        n_win    = r_win;
        ins_en   = 1'b0;
        ins_byte = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_pad   = i_last;
                    n_phase = P_MARK;
                    n_state = i_last ? S_PAD : S_IDLE;
                    if (i_has_byte) begin
                        ins_en   = 1'b1;
                        ins_byte = i_data_byte;
                        n_bits   = r_bits + 64'd8;
                    end
                end
            end
            S_ROUND: begin
                n_work  = rnd_vars;
                n_round = r_round + 6'd1;
                for (int i = 0; i < 15; i++) begin
                    n_win[i] = r_win[i + 1];
                end
                n_win[15] = rnd_w_new;
                if (r_round == ROUND_LAST) begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD: begin
                n_hash[0] = r_hash[0] + r_work.a;
                n_hash[1] = r_hash[1] + r_work.b;
                n_hash[2] = r_hash[2] + r_work.c;
                n_hash[3] = r_hash[3] + r_work.d;
                n_hash[4] = r_hash[4] + r_work.e;
                n_hash[5] = r_hash[5] + r_work.f;
                n_hash[6] = r_hash[6] + r_work.g;
                n_hash[7] = r_hash[7] + r_work.h;
                n_idx     = '0;
                if (!r_pad) begin
                    n_state = S_IDLE;
                end else if (r_phase == P_LEN) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_PAD;
                end
            end
            S_PAD: begin
                unique case (r_phase)
                    P_MARK: begin
                        ins_en   = 1'b1;
                        ins_byte = PAD_MARK;
                        n_phase  = P_ZERO;
                    end
                    P_ZERO: begin
                        if (r_fill == LEN_START) begin
                            n_phase = P_LEN;
                        end else begin
                            ins_en   = 1'b1;
                            ins_byte = '0;
                        end
                    end
                    P_LEN: begin
                        ins_en   = 1'b1;
                        ins_byte = r_bits[{len_sel, 3'b000} +: 8];
                    end
                    default: begin
                        n_phase = P_MARK;
                    end
                endcase
            end
            S_EMIT: begin
                if (i_out_ready) begin
                    // rotate the digest out and refill with the initial hash
                    for (int i = 0; i < 7; i++) begin
                        n_hash[i] = r_hash[i + 1];
                    end
                    n_hash[7] = IV_TAB[r_idx];
                    n_idx     = r_idx + 3'd1;
                    if (r_idx == IDX_LAST) begin
                        n_state = S_IDLE;
                        n_pad   = 1'b0;
                        n_bits  = '0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (ins_en) begin
            for (int i = 0; i < 15; i++) begin
                n_win[i] = {r_win[i][23:0], r_win[i + 1][31:24]};
            end
            n_win[15] = {r_win[15][23:0], ins_byte};
            n_fill    = r_fill + 6'd1;
            if (r_fill == FILL_LAST) begin
                n_state = S_ROUND;
                n_round = '0;
                n_work  = '{r_hash[0], r_hash[1], r_hash[2], r_hash[3],
                            r_hash[4], r_hash[5], r_hash[6], r_hash[7]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_MARK;
            r_pad   <= 1'b0;
            r_fill  <= '0;
            r_round <= '0;
            r_idx   <= '0;
            r_bits  <= '0;
            for (int i = 0; i < 8; i++) begin
                r_hash[i] <= IV_TAB[i];
            end
        end else begin
            r_phase <= n_phase;
            r_pad   <= n_pad;
            r_fill  <= n_fill;
            r_round <= n_round;
            r_idx   <= n_idx;
            r_bits  <= n_bits;
            r_hash  <= n_hash;
        end
    end

    always_ff @(posedge i_clk) begin
        r_work <= n_work;
        r_win  <= n_win;
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = (r_state == S_EMIT);
    assign o_digest_word = r_hash[0];
    assign o_word_index  = r_idx;
    assign o_digest_end  = (r_idx == IDX_LAST);

endmodule

/* rtl/shs_checker.sv */
// port level checks for the sha256 stream hasher, bound to the top level
`timescale 1ns / 1ps
`include "sha256_stream_hasher_defines.svh"

module shs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [7:0]  i_data_byte,
    input logic        i_has_byte,
    input logic        i_last,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_digest_word,
    input logic [2:0]  o_word_index,
    input logic        o_digest_end
);

    // a stalled digest word holds
    `SHS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_digest_word) && $stable(o_word_index))

    // no intake while the digest is being offered
    `SHS_ASSERT_SAME(a_no_overlap, i_clk, i_rst_n, o_out_valid, !o_in_ready)

    // digest words come back to back in index order
    `SHS_ASSERT_NEXT(a_idx_step, i_clk, i_rst_n, o_out_valid && i_out_ready && !o_digest_end, o_out_valid && (o_word_index == 3'($past(o_word_index) + 3'd1)))

    // after the final word the block is ready for a new message
    `SHS_ASSERT_NEXT(a_end_idle, i_clk, i_rst_n, o_out_valid && i_out_ready && o_digest_end, !o_out_valid && o_in_ready)

endmodule

bind sha256_stream_hasher shs_checker u_shs_checker (.*);
